// File: rtl/icar_pkg.sv
// Shared types, codes and the request decoder for the IRQ counter and RAM port block.
`timescale 1ns / 1ps
`default_nettype none

package icar_pkg;

  // RAM geometry
  localparam int RAM_DEPTH = 128;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);

  // Operation codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // Port codes
  localparam logic [1:0] PORT_RAM_DATA = 2'd0;
  localparam logic [1:0] PORT_CNT_LO   = 2'd1;
  localparam logic [1:0] PORT_CNT_HI   = 2'd2;
  localparam logic [1:0] PORT_RAM_ADDR = 2'd3;

  // Counter constants
  localparam logic [15:0] COUNT_TOP     = 16'hFFFF;
  localparam logic [14:0] COUNT_LOW_MAX = 15'h7FFF;

  // Input request
  typedef struct packed {
    logic [1:0] operation;
    logic [1:0] port;
    logic [7:0] data;
  } in_t;

  // Result
  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_line;
  } out_t;

  // Decoded request for the execute stage
  typedef struct packed {
    logic       tick;
    logic       cnt_wr_lo;
    logic       cnt_wr_hi;
    logic       ram_rd;
    logic       ram_wr;
    logic       addr_wr;
    logic [7:0] data;
  } icar_cmd_t;

  // Counter state seen by the execute stage
  typedef struct packed {
    logic [15:0] count;
    logic        irq_next;
  } icar_cnt_stat_t;

  function automatic icar_cmd_t icar_decode(input in_t req);
    icar_cmd_t cmd;
    logic      rd;
    logic      wr;
    rd            = (req.operation == OP_READ);
    wr            = (req.operation == OP_WRITE);
    cmd.tick      = (req.operation == OP_TICK);
    cmd.cnt_wr_lo = wr && (req.port == PORT_CNT_LO);
    cmd.cnt_wr_hi = wr && (req.port == PORT_CNT_HI);
    cmd.ram_rd    = rd && (req.port == PORT_RAM_DATA);
    cmd.ram_wr    = wr && (req.port == PORT_RAM_DATA);
    cmd.addr_wr   = wr && (req.port == PORT_RAM_ADDR);
    cmd.data      = req.data;
    return cmd;
  endfunction

endpackage

`default_nettype wire

// File: rtl/icar_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module icar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/icar_counter.sv
// Cycle counter with enable bit and latched interrupt.
`timescale 1ns / 1ps
`default_nettype none

module icar_counter
  import icar_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      adv_i,
  input  wire icar_cmd_t cmd_i,
  output icar_cnt_stat_t stat_o
);

  logic [15:0] cnt_q, cnt_d;
  logic        irq_q, irq_d;

  // Next counter and interrupt state
  always_comb begin
    cnt_d = cnt_q;
    irq_d = irq_q;
    if (cmd_i.tick && cnt_q[15] && (cnt_q[14:0] != COUNT_LOW_MAX)) begin
      cnt_d = cnt_q + 16'd1;
      if (cnt_d == COUNT_TOP) begin
        irq_d = 1'b1;
      end
    end
    if (cmd_i.cnt_wr_lo) begin
      cnt_d = {cnt_q[15:8], cmd_i.data};
      irq_d = 1'b0;
    end
    if (cmd_i.cnt_wr_hi) begin
      cnt_d = {cmd_i.data, cnt_q[7:0]};
      irq_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      irq_q <= 1'b0;
    end else if (adv_i) begin
      cnt_q <= cnt_d;
      irq_q <= irq_d;
    end
  end

  assign stat_o.count    = cnt_q;
  assign stat_o.irq_next = irq_d;

endmodule

`default_nettype wire

// File: rtl/icar_ram_port.sv
// RAM port: pointer with optional auto-increment, entry valid bits and the RAM.
`timescale 1ns / 1ps
`default_nettype none

module icar_ram_port
  import icar_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       adv_i,
  input  wire icar_cmd_t  cmd_i,
  output logic      [7:0] ram_byte_o
);

  logic [RAM_AW-1:0]    ptr_q;
  logic                 step_q;
  logic [RAM_DEPTH-1:0] valid_q;
  logic                 entry_valid_q;
  logic [7:0]           rdata;
  logic                 re;
  logic                 we;

  assign re = adv_i && cmd_i.ram_rd;
  assign we = adv_i && cmd_i.ram_wr;

  // Pointer and step; data accesses advance by the step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      step_q <= 1'b1;
    end else if (adv_i) begin
      if (cmd_i.addr_wr) begin
        ptr_q  <= cmd_i.data[RAM_AW-1:0];
        step_q <= cmd_i.data[7];
      end else if (cmd_i.ram_rd || cmd_i.ram_wr) begin
        ptr_q <= ptr_q + {{(RAM_AW-1){1'b0}}, step_q};
      end
    end
  end

  // Written entries; unwritten ones read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q       <= '0;
      entry_valid_q <= 1'b0;
    end else begin
      if (we) begin
        valid_q[ptr_q] <= 1'b1;
      end
      if (re) begin
        entry_valid_q <= valid_q[ptr_q];
      end
    end
  end

  icar_ram #(
    .WIDTH(8),
    .DEPTH(RAM_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(ptr_q),
    .wdata_i(cmd_i.data),
    .re_i   (re),
    .raddr_i(ptr_q),
    .rdata_o(rdata)
  );

  // Read data holds until the next RAM read
  assign ram_byte_o = entry_valid_q ? rdata : 8'd0;

endmodule

`default_nettype wire

// File: rtl/irq_counter_and_autoinc_ram_port_top.sv
// Top level: input register, execute logic, result register.
// One request is accepted per cycle, sustained while the result side does not stall;
// each result becomes valid when its request moves from the input register into
// the result register, with the RAM's registered read landing alongside the
// result register. A request is a CPU cycle tick or a bus access to RAM data,
// counter low/high or RAM address.
// The 128-byte RAM comes out of reset reading all zeros at once through per-entry
// valid bits, so there is no clearing pass. Stalls on the result side hold the
// input register and then drop in_ready_o.
`timescale 1ns / 1ps
`default_nettype none

module irq_counter_and_autoinc_ram_port_top
  import icar_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  in_t            in_q;
  logic           in_valid_q;
  logic           out_valid_q;
  logic           out_sel_ram_q;
  logic [7:0]     out_byte_q;
  logic [7:0]     out_byte_d;
  logic           out_irq_q;
  logic           adv;
  icar_cmd_t      cmd;
  icar_cnt_stat_t cnt_stat;
  logic [7:0]     ram_byte;

  // Execute stage moves when the result register is free
  assign adv        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;
  assign cmd        = icar_decode(in_q);

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  icar_counter u_counter (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .adv_i (adv),
    .cmd_i (cmd),
    .stat_o(cnt_stat)
  );

  icar_ram_port u_ram_port (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .cmd_i     (cmd),
    .ram_byte_o(ram_byte)
  );

  // Counter byte reads; everything else but RAM data returns zero
  always_comb begin
    out_byte_d = 8'd0;
    if (in_q.operation == OP_READ) begin
      case (in_q.port)
        PORT_CNT_LO: out_byte_d = cnt_stat.count[7:0];
        PORT_CNT_HI: out_byte_d = cnt_stat.count[15:8];
        default:     out_byte_d = 8'd0;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_sel_ram_q <= cmd.ram_rd;
      out_byte_q    <= out_byte_d;
      out_irq_q     <= cnt_stat.irq_next;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_data_o.read_data = out_sel_ram_q ? ram_byte : out_byte_q;
  assign out_data_o.irq_line  = out_irq_q;

endmodule

`default_nettype wire

// File: rtl/icar_checker.sv
// Port-level checks for the IRQ counter and RAM port block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module icar_checker
  import icar_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire out_t out_data_o
);

  // Input only stalls behind a blocked result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a blocked result");

  // A taken result always frees the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i) |-> in_ready_o)
    else $error("input not ready while result taken");

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

  // No result right out of reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind irq_counter_and_autoinc_ram_port_top icar_checker u_checker (.*);

`default_nettype wire

// File: sim/irq_counter_and_autoinc_ram_port_top_tb.sv
// Self-checking testbench for the cycle counter with IRQ and auto-increment RAM port.
`timescale 1ns / 1ps

module irq_counter_and_autoinc_ram_port_top_tb;
  import icar_pkg::*;

  // Operation code 3 is not decoded by the block and must leave state alone
  localparam logic [1:0]  OP_IGNORED   = 2'd3;
  localparam logic [6:0]  PTR_MASK     = 7'h7F;
  localparam int          CLK_HALF     = 6;
  localparam int          RESET_CYCLES = 11;
  localparam int          NUM_REQUESTS = 1750;
  localparam int          MAX_GAP      = 16;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          CYCLE_LIMIT  = 400000;

  // Tracks counter, IRQ latch and RAM, and checks each result in order
  class irq_ram_scoreboard;
    logic [7:0]  ram_image [RAM_DEPTH];
    logic [6:0]  ram_ptr;
    logic        ptr_step;
    logic [15:0] cycle_cnt;
    logic        irq_latched;
    out_t        expected_results [$];
    int          errors;

    function new();
      foreach (ram_image[i]) ram_image[i] = 8'h00;
      ram_ptr     = '0;
      ptr_step    = 1'b1;
      cycle_cnt   = '0;
      irq_latched = 1'b0;
      errors      = 0;
    endfunction

    // Apply one accepted request and queue the result it must produce
    function void note_request(in_t req);
      out_t res;
      res.read_data = 8'h00;
      case (req.operation)
        OP_TICK: begin
          if (cycle_cnt[15] && (cycle_cnt[14:0] != COUNT_LOW_MAX)) begin
            cycle_cnt = cycle_cnt + 16'd1;
            if (cycle_cnt == COUNT_TOP) irq_latched = 1'b1;
          end
        end
        OP_READ: begin
          case (req.port)
            PORT_RAM_DATA: begin
              res.read_data = ram_image[ram_ptr];
              ram_ptr = (ram_ptr + 7'(ptr_step)) & PTR_MASK;
            end
            PORT_CNT_LO: res.read_data = cycle_cnt[7:0];
            PORT_CNT_HI: res.read_data = cycle_cnt[15:8];
            default:     res.read_data = 8'h00;
          endcase
        end
        OP_WRITE: begin
          case (req.port)
            PORT_RAM_DATA: begin
              ram_image[ram_ptr] = req.data;
              ram_ptr = (ram_ptr + 7'(ptr_step)) & PTR_MASK;
            end
            PORT_CNT_LO: begin
              cycle_cnt[7:0] = req.data;
              irq_latched = 1'b0;
            end
            PORT_CNT_HI: begin
              cycle_cnt[15:8] = req.data;
              irq_latched = 1'b0;
            end
            default: begin
              ram_ptr  = req.data[6:0];
              ptr_step = req.data[7];
            end
          endcase
        end
        default: ;
      endcase
      res.irq_line = irq_latched;
      expected_results.push_back(res);
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result read_data %02h irq_line %0b",
                 $time, got.read_data, got.irq_line);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (got.read_data !== want.read_data) begin
        $display("%0t: read_data expected %02h actual %02h",
                 $time, want.read_data, got.read_data);
        errors++;
      end
      if (got.irq_line !== want.irq_line) begin
        $display("%0t: irq_line expected %0b actual %0b",
                 $time, want.irq_line, got.irq_line);
        errors++;
      end
    endfunction
  endclass

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  in_t  in_data_i   = '0;
  logic out_ready_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  out_t out_data_o;

  irq_ram_scoreboard sb;
  in_t               request_queue [$];
  int                clk_cycles;

  irq_counter_and_autoinc_ram_port_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  task automatic push_req(logic [1:0] op, logic [1:0] port, logic [7:0] data);
    in_t req;
    req.operation = op;
    req.port      = port;
    req.data      = data;
    request_queue.push_back(req);
  endtask

  // Corner cases: disabled counter, count up to 0xFFFF and saturate, IRQ clear, pointer wrap, step 0
  task automatic build_directed();
    push_req(OP_TICK, PORT_RAM_DATA, 8'hFF);   // count 0: disabled, no change
    push_req(OP_READ, PORT_CNT_HI, 8'h00);
    push_req(OP_READ, PORT_CNT_LO, 8'h00);
    push_req(OP_READ, PORT_RAM_ADDR, 8'hFF);   // address port reads as zero
    push_req(OP_WRITE, PORT_CNT_HI, 8'hFF);
    push_req(OP_WRITE, PORT_CNT_LO, 8'hFD);
    push_req(OP_TICK, PORT_CNT_LO, 8'h00);
    push_req(OP_TICK, PORT_CNT_HI, 8'h00);     // reaches top, IRQ latches
    push_req(OP_TICK, PORT_RAM_ADDR, 8'h00);   // saturated, holds
    push_req(OP_READ, PORT_CNT_LO, 8'h00);
    push_req(OP_READ, PORT_CNT_HI, 8'h00);
    push_req(OP_IGNORED, PORT_RAM_ADDR, 8'hFF);
    push_req(OP_WRITE, PORT_CNT_LO, 8'h00);    // clears IRQ
    push_req(OP_WRITE, PORT_CNT_HI, 8'h7F);    // enable bit cleared
    push_req(OP_TICK, PORT_RAM_DATA, 8'h00);
    push_req(OP_WRITE, PORT_CNT_HI, 8'h80);
    push_req(OP_TICK, PORT_RAM_DATA, 8'h00);
    push_req(OP_WRITE, PORT_RAM_ADDR, 8'h7F);  // last entry, no increment
    push_req(OP_WRITE, PORT_RAM_DATA, 8'hAA);
    push_req(OP_READ, PORT_RAM_DATA, 8'h00);
    push_req(OP_WRITE, PORT_RAM_ADDR, 8'hFF);  // last entry, increment on
    push_req(OP_READ, PORT_RAM_DATA, 8'h00);   // pointer wraps to 0
    push_req(OP_READ, PORT_RAM_DATA, 8'h00);
    push_req(OP_WRITE, PORT_RAM_DATA, 8'h55);
    push_req(OP_READ, PORT_CNT_LO, 8'h00);
  endtask

  // Arm the counter close to the top, tick through it, peek and maybe clear
  task automatic build_counter_run();
    logic [7:0] hi;
    int         n_ticks;
    hi = ($urandom_range(0, 3) != 0) ? 8'hFF : (8'h80 | 8'($urandom_range(0, 127)));
    if ($urandom_range(0, 9) == 0) hi[7] = 1'b0;
    push_req(OP_WRITE, PORT_CNT_HI, hi);
    push_req(OP_WRITE, PORT_CNT_LO, 8'hFF - 8'($urandom_range(0, 24)));
    n_ticks = $urandom_range(1, 30);
    for (int i = 0; i < n_ticks; i++) begin
      push_req(OP_TICK, 2'($urandom_range(0, 3)), 8'($urandom));
      if ($urandom_range(0, 5) == 0)
        push_req(OP_READ, ($urandom_range(0, 1) != 0) ? PORT_CNT_LO : PORT_CNT_HI,
                 8'($urandom));
    end
    if ($urandom_range(0, 2) == 0)
      push_req(OP_WRITE, ($urandom_range(0, 1) != 0) ? PORT_CNT_LO : PORT_CNT_HI,
               8'($urandom));
  endtask

  // Fill a stretch of RAM, rewind the pointer and read it back
  task automatic build_ram_burst();
    logic [7:0] addr;
    int         len;
    addr = 8'($urandom);
    if ($urandom_range(0, 4) != 0) addr[7] = 1'b1;
    len = $urandom_range(1, 20);
    push_req(OP_WRITE, PORT_RAM_ADDR, addr);
    for (int i = 0; i < len; i++) push_req(OP_WRITE, PORT_RAM_DATA, 8'($urandom));
    push_req(OP_WRITE, PORT_RAM_ADDR, addr);
    for (int i = 0; i < len; i++) push_req(OP_READ, PORT_RAM_DATA, 8'($urandom));
  endtask

  task automatic build_noise();
    int n;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++)
      push_req(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), 8'($urandom));
  endtask

  // Request side: random gaps, with some stretches of back-to-back requests
  task automatic drive_requests();
    int gap_max;
    int gap;
    in_t req;
    gap_max = MAX_GAP;
    for (int idx = 0; request_queue.size() != 0; idx++) begin
      req = request_queue.pop_front();
      if (idx % 64 == 0) gap_max = ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_data_i  <= req;
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
      sb.note_request(req);
    end
    in_valid_i <= 1'b0;
  endtask

  // Result side: random stalls, with some stretches of ready held high
  task automatic accept_results();
    int stall_max;
    int stall;
    stall_max = MAX_GAP;
    for (int idx = 0; ; idx++) begin
      if (idx % 64 == 0) stall_max = ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP;
      stall = $urandom_range(0, stall_max);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      sb.check_result(out_data_o);
    end
  endtask

  // Watchdog
  initial begin
    clk_cycles = 0;
    while (clk_cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      clk_cycles++;
    end
    $display("irq_counter_and_autoinc_ram_port_top_tb: errors");
    $finish;
  end

  initial begin
    sb = new();
    build_directed();
    while (request_queue.size() < NUM_REQUESTS) begin
      case ($urandom_range(0, 4))
        0, 1:    build_counter_run();
        2, 3:    build_ram_burst();
        default: build_noise();
      endcase
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    fork
      accept_results();
    join_none
    drive_requests();

    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("irq_counter_and_autoinc_ram_port_top_tb: clean");
    end else begin
      $display("irq_counter_and_autoinc_ram_port_top_tb: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/icar_pkg.sv
rtl/icar_ram.sv
rtl/icar_counter.sv
rtl/icar_ram_port.sv
rtl/irq_counter_and_autoinc_ram_port_top.sv
rtl/icar_checker.sv
sim/irq_counter_and_autoinc_ram_port_top_tb.sv
